// ----- src/sam_pkg.sv -----
// ----------------------------------------------------------------------------
// sam_pkg
// Shared constants and memory request types for the suffix automaton core.
// ----------------------------------------------------------------------------
package sam_pkg;

  localparam int MAX_LEN  = 2048;
  localparam int ALPHABET = 26;
  localparam int NSTATES  = 2 * MAX_LEN;

  localparam int SYM_W   = 5;
  localparam int COUNT_W = 22;
  localparam int STATE_W = $clog2(NSTATES);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int COL_W   = $clog2(ALPHABET);
  localparam int TR_AW   = STATE_W + COL_W;
  localparam int TR_DEPTH = NSTATES * (2 ** COL_W);

  typedef logic [STATE_W-1:0] state_idx_t;

  typedef struct packed {
    logic                 we;
    logic [STATE_W-1:0]   waddr;
    logic [STATE_W-1:0]   wdata;
    logic [STATE_W-1:0]   raddr;
  } st_req_t;

  typedef struct packed {
    logic               we;
    logic [TR_AW-1:0]   waddr;
    logic [STATE_W-1:0] wdata;
    logic [TR_AW-1:0]   raddr;
  } tr_req_t;

endpackage

// ----- src/sam_ram.sv -----
// ----------------------------------------------------------------------------
// sam_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/sam_seq.sv -----
// ----------------------------------------------------------------------------
// sam_seq
// Sequencer: runs extend, clone and link walks against the state memories.
// ----------------------------------------------------------------------------
module sam_seq
  import sam_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SYM_W-1:0]   symbol_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COUNT_W-1:0] distinct_count_o,
  output logic               overflow_o,
  output st_req_t            len_req_o,
  input  logic [STATE_W-1:0] len_rd_i,
  output st_req_t            lnk_req_o,
  input  logic [STATE_W-1:0] lnk_rd_i,
  output tr_req_t            tr_req_o,
  input  logic [STATE_W-1:0] tr_rd_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_RCLR, S_DEC, S_ESTART, S_ELEN, S_ECLR, S_WRD, S_WCHK,
    S_QRD, S_QRD2, S_QCHK, S_CRD, S_CWR, S_CLNK, S_CLNK2, S_RRD, S_RCHK,
    S_RFIN, S_RFIN2, S_FIN, S_FIN2, S_DONE
  } seq_e;

  localparam logic [COL_W-1:0] LastCol = COL_W'(ALPHABET - 1);

  seq_e               state_q;
  logic [SYM_W-1:0]   sym_q;
  logic [COL_W-1:0]   col_q;
  state_idx_t         p_q, q_q, cur_q, cl_q, lnk_q, scount_q, last_q;
  logic [STATE_W-1:0] lencur_q, lenp1_q;
  logic [LEN_W-1:0]   slen_q;
  logic [COUNT_W-1:0] total_q;
  logic               init_q, ovf_q;
  logic               out_valid_q, out_ovf_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [COL_W-1:0]   sym_col;
  logic               rs;

  assign sym_col          = sym_q[COL_W-1:0];
  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign distinct_count_o = out_count_q;
  assign overflow_o       = out_ovf_q;
  assign rs               = restart_i | init_q;

  always_comb begin
    len_req_o = '0;
    lnk_req_o = '0;
    tr_req_o  = '0;
    unique case (state_q)
      S_RCLR: begin
        tr_req_o.we    = 1'b1;
        tr_req_o.waddr = {STATE_W'(0), col_q};
        len_req_o.we   = (col_q == '0);
        lnk_req_o.we   = (col_q == '0);
      end
      S_ESTART: len_req_o.raddr = last_q;
      S_ELEN: begin
        len_req_o.we    = 1'b1;
        len_req_o.waddr = cur_q;
        len_req_o.wdata = len_rd_i + STATE_W'(1);
      end
      S_ECLR: begin
        tr_req_o.we    = 1'b1;
        tr_req_o.waddr = {cur_q, col_q};
      end
      S_WRD, S_RRD: begin
        tr_req_o.raddr  = {p_q, sym_col};
        lnk_req_o.raddr = p_q;
      end
      S_WCHK: begin
        tr_req_o.we     = (tr_rd_i == '0);
        tr_req_o.waddr  = {p_q, sym_col};
        tr_req_o.wdata  = cur_q;
        lnk_req_o.we    = (tr_rd_i == '0) && (p_q == '0);
        lnk_req_o.waddr = cur_q;
      end
      S_QRD:  len_req_o.raddr = p_q;
      S_QRD2: len_req_o.raddr = q_q;
      S_QCHK: begin
        if (lenp1_q == len_rd_i) begin
          lnk_req_o.we    = 1'b1;
          lnk_req_o.waddr = cur_q;
          lnk_req_o.wdata = q_q;
        end else begin
          len_req_o.we    = 1'b1;
          len_req_o.waddr = scount_q + STATE_W'(1);
          len_req_o.wdata = lenp1_q;
        end
      end
      S_CRD: tr_req_o.raddr = {q_q, col_q};
      S_CWR: begin
        tr_req_o.we    = 1'b1;
        tr_req_o.waddr = {cl_q, col_q};
        tr_req_o.wdata = tr_rd_i;
      end
      S_CLNK: lnk_req_o.raddr = q_q;
      S_CLNK2: begin
        lnk_req_o.we    = 1'b1;
        lnk_req_o.waddr = cl_q;
        lnk_req_o.wdata = lnk_rd_i;
      end
      S_RCHK: begin
        tr_req_o.we    = (tr_rd_i == q_q);
        tr_req_o.waddr = {p_q, sym_col};
        tr_req_o.wdata = cl_q;
      end
      S_RFIN: begin
        lnk_req_o.we    = 1'b1;
        lnk_req_o.waddr = q_q;
        lnk_req_o.wdata = cl_q;
      end
      S_RFIN2: begin
        lnk_req_o.we    = 1'b1;
        lnk_req_o.waddr = cur_q;
        lnk_req_o.wdata = cl_q;
      end
      S_FIN: len_req_o.raddr = lnk_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      init_q      <= 1'b1;
      scount_q    <= '0;
      last_q      <= '0;
      total_q     <= '0;
      slen_q      <= '0;
      out_valid_q <= 1'b0;
      out_ovf_q   <= 1'b0;
      out_count_q <= '0;
      ovf_q       <= 1'b0;
      col_q       <= '0;
      sym_q       <= '0;
      p_q <= '0; q_q <= '0; cur_q <= '0; cl_q <= '0; lnk_q <= '0;
      lencur_q <= '0; lenp1_q <= '0;
    end else begin
      if ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
        out_count_q <= total_q;
        out_ovf_q   <= ovf_q;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            sym_q  <= symbol_i;
            init_q <= 1'b0;
            col_q  <= '0;
            if (rs) begin
              scount_q <= '0;
              last_q   <= '0;
              total_q  <= '0;
              slen_q   <= '0;
              state_q  <= S_RCLR;
            end else begin
              state_q <= S_DEC;
            end
          end
        end
        S_RCLR: begin
          col_q <= col_q + COL_W'(1);
          if (col_q == LastCol) state_q <= S_DEC;
        end
        S_DEC: begin
          ovf_q <= 1'b0;
          if (sym_q < SYM_W'(ALPHABET)) begin
            if (slen_q >= LEN_W'(MAX_LEN)) begin
              ovf_q   <= 1'b1;
              state_q <= S_DONE;
            end else begin
              state_q <= S_ESTART;
            end
          end else begin
            state_q <= S_DONE;
          end
        end
        S_ESTART: begin
          cur_q    <= scount_q + STATE_W'(1);
          scount_q <= scount_q + STATE_W'(1);
          state_q  <= S_ELEN;
        end
        S_ELEN: begin
          lencur_q <= len_rd_i + STATE_W'(1);
          col_q    <= '0;
          state_q  <= S_ECLR;
        end
        S_ECLR: begin
          col_q <= col_q + COL_W'(1);
          if (col_q == LastCol) begin
            p_q     <= last_q;
            state_q <= S_WRD;
          end
        end
        S_WRD: state_q <= S_WCHK;
        S_WCHK: begin
          if (tr_rd_i != '0) begin
            q_q     <= tr_rd_i;
            state_q <= S_QRD;
          end else if (p_q == '0) begin
            lnk_q   <= '0;
            state_q <= S_FIN;
          end else begin
            p_q     <= lnk_rd_i;
            state_q <= S_WRD;
          end
        end
        S_QRD:  state_q <= S_QRD2;
        S_QRD2: begin
          lenp1_q <= len_rd_i + STATE_W'(1);
          state_q <= S_QCHK;
        end
        S_QCHK: begin
          if (lenp1_q == len_rd_i) begin
            lnk_q   <= q_q;
            state_q <= S_FIN;
          end else begin
            cl_q     <= scount_q + STATE_W'(1);
            scount_q <= scount_q + STATE_W'(1);
            col_q    <= '0;
            state_q  <= S_CRD;
          end
        end
        S_CRD: state_q <= S_CWR;
        S_CWR: begin
          col_q   <= col_q + COL_W'(1);
          state_q <= (col_q == LastCol) ? S_CLNK : S_CRD;
        end
        S_CLNK:  state_q <= S_CLNK2;
        S_CLNK2: state_q <= S_RRD;
        S_RRD:   state_q <= S_RCHK;
        S_RCHK: begin
          if (tr_rd_i != q_q || p_q == '0) begin
            state_q <= S_RFIN;
          end else begin
            p_q     <= lnk_rd_i;
            state_q <= S_RRD;
          end
        end
        S_RFIN: state_q <= S_RFIN2;
        S_RFIN2: begin
          lnk_q   <= cl_q;
          state_q <= S_FIN;
        end
        S_FIN: state_q <= S_FIN2;
        S_FIN2: begin
          total_q <= total_q + COUNT_W'(lencur_q - len_rd_i);
          last_q  <= cur_q;
          slen_q  <= slen_q + LEN_W'(1);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/suffix_automaton_distinct_substrings_core.sv -----
// ----------------------------------------------------------------------------
// suffix_automaton_distinct_substrings_core
// Online suffix automaton; reports the distinct substring count per beat.
// ----------------------------------------------------------------------------
// One input beat is taken at a time. A beat's work grows with each
// suffix-link step, with a restart, when the walk stops at an existing
// transition, and when a clone is made and with each redirected link; the
// cost comes from the one-read-per-cycle state and transition memories that
// every step of the sequencer goes through. A result waits in an output
// register while the next beat is already taken.
module suffix_automaton_distinct_substrings_core
  import sam_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SYM_W-1:0]   symbol_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COUNT_W-1:0] distinct_count_o,
  output logic               overflow_o
);

  st_req_t            len_req, lnk_req;
  tr_req_t            tr_req;
  logic [STATE_W-1:0] len_rd, lnk_rd, tr_rd;

  sam_seq u_seq (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .symbol_i, .restart_i,
    .out_valid_o, .out_ready_i, .distinct_count_o, .overflow_o,
    .len_req_o(len_req), .len_rd_i(len_rd),
    .lnk_req_o(lnk_req), .lnk_rd_i(lnk_rd),
    .tr_req_o(tr_req),   .tr_rd_i(tr_rd)
  );

  sam_ram #(.WIDTH(STATE_W), .DEPTH(NSTATES)) u_len_ram (
    .clk_i, .we_i(len_req.we), .waddr_i(len_req.waddr),
    .wdata_i(len_req.wdata), .raddr_i(len_req.raddr), .rdata_o(len_rd)
  );

  sam_ram #(.WIDTH(STATE_W), .DEPTH(NSTATES)) u_lnk_ram (
    .clk_i, .we_i(lnk_req.we), .waddr_i(lnk_req.waddr),
    .wdata_i(lnk_req.wdata), .raddr_i(lnk_req.raddr), .rdata_o(lnk_rd)
  );

  sam_ram #(.WIDTH(STATE_W), .DEPTH(TR_DEPTH)) u_tr_ram (
    .clk_i, .we_i(tr_req.we), .waddr_i(tr_req.waddr),
    .wdata_i(tr_req.wdata), .raddr_i(tr_req.raddr), .rdata_o(tr_rd)
  );

endmodule
